// File: design/tile_map_box_collision_defines.svh
// Assertion macros used by the top-level design file.
`ifndef TILE_MAP_BOX_COLLISION_DEFINES_SVH
`define TILE_MAP_BOX_COLLISION_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, masked while reset is asserted.
`define TMBC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property, active during reset as well.
`define TMBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMBC_ASSERT(lbl, clk, rstn, prop, msg)
`define TMBC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/tmbc_pkg.sv
`timescale 1ns / 1ps

package tmbc_pkg;

  // Map geometry
  localparam int TILE_SHIFT = 6;
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 256;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 8;
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int DEPTH      = MAX_COLS * MAX_ROWS;

  // Word field widths
  localparam int CODE_W  = 11;
  localparam int POS_W   = 18;
  localparam int SIZE_W  = 16;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  // Tile codes stored as empty
  localparam logic signed [CODE_W-1:0] TILE_BLANK = -11'sd1;
  localparam logic signed [CODE_W-1:0] TILE_GOAL  = 11'sd100;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS = 1'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;    // write zero at clear address
    logic wr_tile;   // store accepted tile word
    logic q_load;    // latch accepted query box
    logic calc;      // register scan bounds
    logic scan;      // issue one tile read and step
    logic res_load;  // load output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic side_hit;
    logic empty;
    logic scan_last;
    logic hit_seen;
    logic out_free;
  } stat_t;

endpackage

// File: design/tile_map_box_collision.sv
`timescale 1ns / 1ps
// Tile map collision check for axis-aligned boxes.
// Input channel (in_valid / in_stall): a word with in_action 0 stores one tile
// (codes -1 and 100 empty, others solid); in_action 1 queries a box.
// Result channel (out_valid / out_stall): one out_hit word per query, none
// per tile write. Configuration channel (cfg_valid / cfg_ready, always ready):
// index 0 sets map_cols, index 1 sets map_rows; write only while idle.
// A query runs through CALC (scan bounds), SCAN and, unless a hit ends
// the scan, WAIT to DONE, which puts its result in the output register;
// the next word is taken once the controller is back in IDLE. A query that
// leaves the map sideways or covers no tile goes from CALC to DONE. The
// scan reads one tile a cycle through the single read port of the tile
// store and stops once a solid tile has been read. Reset: the tile store is
// swept to empty, one tile a cycle, while in_stall stays high; configuration
// writes are taken. A result held by out_stall stays in the output register;
// tile writes are still taken then, and a query runs but waits before loading its result.
`include "tile_map_box_collision_defines.svh"

module tile_map_box_collision (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic [tmbc_pkg::COL_W-1:0]           in_tile_col,
  input  logic [tmbc_pkg::ROW_W-1:0]           in_tile_row,
  input  logic signed [tmbc_pkg::CODE_W-1:0]   in_tile_code,
  input  logic signed [tmbc_pkg::POS_W-1:0]    in_box_x,
  input  logic signed [tmbc_pkg::POS_W-1:0]    in_box_y,
  input  logic [tmbc_pkg::SIZE_W-1:0]          in_box_w,
  input  logic [tmbc_pkg::SIZE_W-1:0]          in_box_h,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_hit,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tmbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmbc_pkg::CFG_W-1:0]           cfg_data
);

  tmbc_pkg::cmd_t  cmd;
  tmbc_pkg::stat_t stat;

  logic                        ram_we, ram_wdata, ram_re, ram_rdata;
  logic [tmbc_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;

  tmbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmbc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_tile_col  (in_tile_col),
    .in_tile_row  (in_tile_row),
    .in_tile_code (in_tile_code),
    .in_box_x     (in_box_x),
    .in_box_y     (in_box_y),
    .in_box_w     (in_box_w),
    .in_box_h     (in_box_h),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hit      (out_hit)
  );

  tmbc_ram #(
    .WIDTH (1),
    .DEPTH (tmbc_pkg::DEPTH)
  ) u_tiles (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Checks
  `TMBC_ASSERT_ALWAYS(a_stall_after_reset, clk, !rst_n |=> in_stall, "input open after reset")
  `TMBC_ASSERT(a_query_blocks, clk, rst_n, (in_valid && !in_stall && in_action) |=> in_stall, "query not blocking")
  `TMBC_ASSERT(a_result_from_busy, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "result without query")
  `TMBC_ASSERT(a_port_excl, clk, rst_n, $onehot0({cmd.clr_en, cmd.wr_tile, cmd.scan}), "store port clash")

endmodule

// File: design/tmbc_ram.sv
`timescale 1ns / 1ps

module tmbc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/tmbc_ctrl.sv
`timescale 1ns / 1ps

module tmbc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_action,
  output logic            in_stall,
  input  tmbc_pkg::stat_t stat,
  output tmbc_pkg::cmd_t  cmd
);

  tmbc_pkg::state_t state_r, state_nxt;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmbc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign accept = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tmbc_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_nxt = tmbc_pkg::ST_IDLE;
      end
      tmbc_pkg::ST_IDLE: begin
        if (accept && in_action) state_nxt = tmbc_pkg::ST_CALC;
      end
      tmbc_pkg::ST_CALC: begin
        if (stat.side_hit || stat.empty) state_nxt = tmbc_pkg::ST_DONE;
        else state_nxt = tmbc_pkg::ST_SCAN;
      end
      tmbc_pkg::ST_SCAN: begin
        if (stat.hit_seen) state_nxt = tmbc_pkg::ST_DONE;
        else if (stat.scan_last) state_nxt = tmbc_pkg::ST_WAIT;
      end
      tmbc_pkg::ST_WAIT: begin
        state_nxt = tmbc_pkg::ST_DONE;
      end
      tmbc_pkg::ST_DONE: begin
        if (stat.out_free) state_nxt = tmbc_pkg::ST_IDLE;
      end
      default: state_nxt = tmbc_pkg::ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      tmbc_pkg::ST_CLEAR: cmd.clr_en = 1'b1;
      tmbc_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.wr_tile = accept && !in_action;
        cmd.q_load  = accept && in_action;
      end
      tmbc_pkg::ST_CALC: cmd.calc = 1'b1;
      tmbc_pkg::ST_SCAN: cmd.scan = !stat.hit_seen;
      tmbc_pkg::ST_WAIT: cmd = '0;
      tmbc_pkg::ST_DONE: cmd.res_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/tmbc_dp.sv
`timescale 1ns / 1ps

module tmbc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tmbc_pkg::cmd_t                       cmd,
  output tmbc_pkg::stat_t                      stat,
  // input word fields
  input  logic [tmbc_pkg::COL_W-1:0]           in_tile_col,
  input  logic [tmbc_pkg::ROW_W-1:0]           in_tile_row,
  input  logic signed [tmbc_pkg::CODE_W-1:0]   in_tile_code,
  input  logic signed [tmbc_pkg::POS_W-1:0]    in_box_x,
  input  logic signed [tmbc_pkg::POS_W-1:0]    in_box_y,
  input  logic [tmbc_pkg::SIZE_W-1:0]          in_box_w,
  input  logic [tmbc_pkg::SIZE_W-1:0]          in_box_h,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tmbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmbc_pkg::CFG_W-1:0]           cfg_data,
  // tile store
  output logic                                 ram_we,
  output logic [tmbc_pkg::ADDR_W-1:0]          ram_waddr,
  output logic                                 ram_wdata,
  output logic                                 ram_re,
  output logic [tmbc_pkg::ADDR_W-1:0]          ram_raddr,
  input  logic                                 ram_rdata,
  // result word
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_hit
);

  localparam int CW = tmbc_pkg::COL_W;
  localparam int RW = tmbc_pkg::ROW_W;
  localparam int TS = tmbc_pkg::TILE_SHIFT;
  localparam logic signed [19:0] TILE_PX_S = 20'sd1 <<< TS;

  // Configuration registers
  logic [10:0] map_cols_r;
  logic [8:0]  map_rows_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_cols_r <= 11'd1;
      map_rows_r <= 9'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tmbc_pkg::CFG_MAP_COLS: map_cols_r <= cfg_data;
        tmbc_pkg::CFG_MAP_ROWS: map_rows_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Clear sweep address
  logic [tmbc_pkg::ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Tile write: blank and goal codes store as empty
  logic tile_solid;
  assign tile_solid = !(in_tile_code == tmbc_pkg::TILE_BLANK ||
                        in_tile_code == tmbc_pkg::TILE_GOAL);

  assign ram_we    = cmd.clr_en || cmd.wr_tile;
  assign ram_waddr = cmd.clr_en ? clr_addr_r : {in_tile_row, in_tile_col};
  assign ram_wdata = cmd.clr_en ? 1'b0 : tile_solid;

  // Latched query box
  logic signed [tmbc_pkg::POS_W-1:0] q_x_r, q_y_r;
  logic [tmbc_pkg::SIZE_W-1:0]       q_w_r, q_h_r;

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      q_x_r <= in_box_x;
      q_y_r <= in_box_y;
      q_w_r <= in_box_w;
      q_h_r <= in_box_h;
    end
  end

  // Effective map size and its pixel extent
  logic [10:0] cols;
  logic [8:0]  rows;
  logic signed [19:0] mright_s, mbottom_s;

  always_comb begin
    if (map_cols_r == 11'd0) cols = 11'd1;
    else if (map_cols_r > 11'(tmbc_pkg::MAX_COLS)) cols = 11'(tmbc_pkg::MAX_COLS);
    else cols = map_cols_r;
    if (map_rows_r == 9'd0) rows = 9'd1;
    else if (map_rows_r > 9'(tmbc_pkg::MAX_ROWS)) rows = 9'(tmbc_pkg::MAX_ROWS);
    else rows = map_rows_r;
  end

  assign mright_s  = signed'(20'(cols) << TS);
  assign mbottom_s = signed'(20'(rows) << TS);

  // Box edges and tile bounds
  logic signed [19:0] left_s, top_s, right_s, bottom_s;
  logic signed [19:0] rm1_s, top_c_s, bot_c_s, bm1_s;
  logic [10:0]   sx, sy;
  logic [CW-1:0] ex;
  logic [RW-1:0] ey;
  logic          ey_none, side_hit;

  always_comb begin
    left_s   = 20'(q_x_r);
    top_s    = 20'(q_y_r);
    right_s  = left_s + signed'(20'(q_w_r));
    bottom_s = top_s + signed'(20'(q_h_r));
    side_hit = left_s[19] || (right_s > mright_s);
    // columns: left is known nonnegative when no side hit
    sx    = 11'(left_s >>> TS);
    rm1_s = right_s - 20'sd1;
    ex    = rm1_s[19] ? '0 : CW'(rm1_s >>> TS);
    // rows: clamp to the map, end index truncates toward zero
    top_c_s = top_s[19] ? 20'sd0 : top_s;
    sy      = 11'(top_c_s >>> TS);
    bot_c_s = (bottom_s > mbottom_s) ? mbottom_s : bottom_s;
    bm1_s   = bot_c_s - 20'sd1;
    ey_none = (bm1_s <= -TILE_PX_S);
    ey      = bm1_s[19] ? '0 : RW'(bm1_s >>> TS);
  end

  // Scan bounds and tile counters
  logic [CW-1:0] sx_r, ex_r, x_r;
  logic [RW-1:0] ey_r, y_r;
  logic          x_end;

  assign x_end = (x_r == ex_r);

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      sx_r <= CW'(sx);
      ex_r <= ex;
      ey_r <= ey;
      x_r  <= CW'(sx);
      y_r  <= RW'(sy);
    end else if (cmd.scan) begin
      if (x_end) begin
        x_r <= sx_r;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  assign ram_re    = cmd.scan;
  assign ram_raddr = {y_r, x_r};

  // Hit accumulation over returning reads
  logic rd_valid_r, hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      rd_valid_r <= cmd.scan;
      if (cmd.q_load) hit_r <= 1'b0;
      else if (cmd.calc) hit_r <= side_hit;
      else if (rd_valid_r && ram_rdata) hit_r <= 1'b1;
    end
  end

  // Output register
  logic out_valid_r, out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) out_hit_r <= hit_r;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // Status
  assign stat.clr_last  = &clr_addr_r;
  assign stat.side_hit  = side_hit;
  assign stat.empty     = ey_none || (sx > 11'(ex)) || (sy > 11'(ey));
  assign stat.scan_last = x_end && (y_r == ey_r);
  assign stat.hit_seen  = hit_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule
